@@ rtl/core/bpe_symbol_expander_unit_defines.svh @@
// Assertion macros for the symbol expander.
`ifndef BPE_SYMBOL_EXPANDER_UNIT_DEFINES_SVH
`define BPE_SYMBOL_EXPANDER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BPE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpe assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BPE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpe assertion failed");

`endif

@@ rtl/core/bpe_pkg.sv @@
`default_nettype none

package bpe_pkg;

  localparam int TABLE_ENTRIES = 240;
  localparam int STACK_DEPTH   = 16;
  localparam int MAX_CHARS     = 64;
  localparam int RESULT_LIMIT  = 64;

  localparam int CODE_W  = 8;
  localparam int BYTES_W = 32;
  localparam int LEN_W   = 3;
  localparam int TAB_AW  = $clog2(TABLE_ENTRIES);
  localparam int SP_W    = $clog2(STACK_DEPTH);
  localparam int LVL_W   = $clog2(STACK_DEPTH + 1);
  localparam int CHAR_W  = $clog2(MAX_CHARS + 1);

  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 2;

  localparam logic [CODE_W-1:0] END_CODE = 8'hF0;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_DECODE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_UNUSED  = 2'd0,
    KIND_LITERAL = 2'd1,
    KIND_PAIR    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_END      = 2'd1,
    ST_UNUSED   = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_DECODE = 2'd1,
    CMD_END    = 2'd2,
    CMD_BAD    = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t              op;
    logic [CODE_W-1:0]    code;
    kind_t                kind;
    logic [BYTES_W-1:0]   data;
  } cmd_t;

  typedef struct packed {
    kind_t                kind;
    logic [BYTES_W-1:0]   data;
  } entry_t;

  typedef struct packed {
    logic [BYTES_W-1:0]   char_bytes;
    logic [LEN_W-1:0]     char_len;
    logic                 last;
    status_t              status;
  } res_t;

  function automatic logic in_table(input logic [CODE_W-1:0] c);
    return {1'b0, c} < (CODE_W + 1)'(TABLE_ENTRIES);
  endfunction

  function automatic logic code_ok(input logic [CODE_W-1:0] c);
    return (c < END_CODE) && in_table(c);
  endfunction

  function automatic logic [LEN_W-1:0] utf8_len(input logic [7:0] lead);
    logic [LEN_W-1:0] len;
    if (lead < 8'h80) len = LEN_W'(1);
    else if (lead >= 8'hC0 && lead <= 8'hDF) len = LEN_W'(2);
    else if (lead >= 8'hE0 && lead <= 8'hEF) len = LEN_W'(3);
    else if (lead >= 8'hF0 && lead <= 8'hF7) len = LEN_W'(4);
    else len = LEN_W'(1);
    return len;
  endfunction

  function automatic logic [BYTES_W-1:0] utf8_mask(input logic [BYTES_W-1:0] val,
                                                   input logic [LEN_W-1:0] len);
    logic [BYTES_W-1:0] res;
    case (len)
      LEN_W'(1): res = {24'h0, val[7:0]};
      LEN_W'(2): res = {16'h0, val[15:0]};
      LEN_W'(3): res = {8'h0, val[23:0]};
      default:   res = val;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/bpe_symbol_expander_unit.sv @@
// Byte-pair symbol expander.
// Input queue (in_push / in_full): each transaction is a table write
// (in_opcode 0) or a decode of one code (in_opcode 1). Writes give no result.
// Result queue (out_empty / out_pop): the oldest result sits on the out_
// ports while out_empty is low; one decode gives one result per UTF-8
// character, the final one flagged by out_last, or ends in one status result.
// The back end takes each accepted item from the command queue. An end
// marker's status result is pushed into the result queue as it is taken;
// a decode first reads the code's entry, then one entry per pair on the path
// down to its first character. A write is stored as it is taken; a decode
// reads each table entry visited (pairs and literals alike) through the
// single read port of the 240-entry table, and the back end takes no new
// item until its walk ends. A two-entry queue sits between front and back.
// Reset marks every table entry unused and empties both queues.
// A stalled receiver fills the result queue, then holds the walk, then
// the input queue fills and in_full rises; nothing is dropped.
`default_nettype none

module bpe_symbol_expander_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_opcode,
  input  logic [7:0]  in_code,
  input  logic [1:0]  in_entry_kind,
  input  logic [7:0]  in_left_child,
  input  logic [7:0]  in_right_child,
  input  logic [31:0] in_literal_utf8,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_char_bytes,
  output logic [2:0]  out_char_len,
  output logic        out_last,
  output logic [1:0]  out_status
);
  import bpe_pkg::*;

  logic  cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t  cmd_in, cmd_out;
  logic  res_push, res_full;
  res_t  res_in, res_out;

  bpe_front u_front (
    .in_push         (in_push),
    .in_full         (in_full),
    .in_opcode       (in_opcode),
    .in_code         (in_code),
    .in_entry_kind   (in_entry_kind),
    .in_left_child   (in_left_child),
    .in_right_child  (in_right_child),
    .in_literal_utf8 (in_literal_utf8),
    .cmd_push        (cmd_push),
    .cmd             (cmd_in),
    .cmd_full        (cmd_full)
  );

  bpe_cmd_queue u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  bpe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  bpe_res_queue u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (res_out),
    .empty     (out_empty)
  );

  assign out_char_bytes = res_out.char_bytes;
  assign out_char_len   = res_out.char_len;
  assign out_last       = res_out.last;
  assign out_status     = res_out.status;

endmodule

`default_nettype wire

@@ rtl/core/bpe_front.sv @@
`default_nettype none

module bpe_front (
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_opcode,
  input  logic [7:0]            in_code,
  input  logic [1:0]            in_entry_kind,
  input  logic [7:0]            in_left_child,
  input  logic [7:0]            in_right_child,
  input  logic [31:0]           in_literal_utf8,
  output logic                  cmd_push,
  output bpe_pkg::cmd_t         cmd,
  input  logic                  cmd_full
);
  import bpe_pkg::*;

  logic drop;

  always_comb begin
    cmd      = '0;
    drop     = 1'b0;
    cmd.code = in_code;
    if (in_opcode == OP_WRITE) begin
      cmd.op = CMD_WRITE;
      drop   = !in_table(in_code);
      unique case (in_entry_kind)
        KIND_LITERAL: begin
          cmd.kind = KIND_LITERAL;
          cmd.data = in_literal_utf8;
        end
        KIND_PAIR: begin
          cmd.kind = KIND_PAIR;
          cmd.data = {16'h0, in_left_child, in_right_child};
        end
        default: begin
          cmd.kind = KIND_UNUSED;
          cmd.data = '0;
        end
      endcase
    end else if (in_code >= END_CODE) begin
      cmd.op = CMD_END;
    end else if (!in_table(in_code)) begin
      cmd.op = CMD_BAD;
    end else begin
      cmd.op = CMD_DECODE;
    end
  end

  assign in_full  = cmd_full;
  assign cmd_push = in_push && !cmd_full && !drop;

endmodule

`default_nettype wire

@@ rtl/core/bpe_cmd_queue.sv @@
`default_nettype none

module bpe_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bpe_pkg::cmd_t  push_data,
  output logic           full,
  input  logic           pop,
  output bpe_pkg::cmd_t  pop_data,
  output logic           empty
);
  import bpe_pkg::*;

  localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t            slot_r [CMDQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full     = (cnt_r == CW'(CMDQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bpe_res_queue.sv @@
`default_nettype none

module bpe_res_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bpe_pkg::res_t  push_data,
  output logic           full,
  input  logic           pop,
  output bpe_pkg::res_t  pop_data,
  output logic           empty
);
  import bpe_pkg::*;

  localparam int PW = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
  localparam int CW = $clog2(RESQ_DEPTH + 1);

  res_t            slot_r [RESQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full     = (cnt_r == CW'(RESQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(RESQ_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(RESQ_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bpe_back.sv @@
`default_nettype none

module bpe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_empty,
  input  bpe_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output bpe_pkg::res_t  res
);
  import bpe_pkg::*;

  localparam bit SUPPRESS_EN = (MAX_CHARS >= RESULT_LIMIT);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  entry_t               tab_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] tab_vld_r;
  entry_t               rd_ent_r;
  logic                 rd_vld_r;
  logic                 rd_bad_r;
  logic [CODE_W-1:0]    stk_r [STACK_DEPTH];
  logic [LVL_W-1:0]     level_r, level_nxt;
  logic [CHAR_W-1:0]    chars_r, chars_nxt;

  logic                 rd_en;
  logic [CODE_W-1:0]    rd_addr;
  logic                 wr_en;
  logic                 stk_push;
  logic                 stk_empty;
  logic                 stk_full;
  logic [SP_W-1:0]      top_idx;
  kind_t                cur_kind;
  logic [LEN_W-1:0]     lit_len;

  assign stk_empty = (level_r == '0);
  assign stk_full  = (level_r == LVL_W'(STACK_DEPTH));
  assign top_idx   = level_r[SP_W-1:0] - SP_W'(1);
  assign cur_kind  = (rd_bad_r || !rd_vld_r) ? KIND_UNUSED : rd_ent_r.kind;
  assign lit_len   = utf8_len(rd_ent_r.data[7:0]);

  always_comb begin
    state_nxt = state_r;
    level_nxt = level_r;
    chars_nxt = chars_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    rd_en     = 1'b0;
    rd_addr   = cmd.code;
    wr_en     = 1'b0;
    stk_push  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            CMD_WRITE: wr_en = 1'b1;
            CMD_DECODE: begin
              rd_en     = 1'b1;
              level_nxt = '0;
              chars_nxt = '0;
              state_nxt = S_WALK;
            end
            CMD_END: begin
              res_push   = 1'b1;
              res.last   = 1'b1;
              res.status = ST_END;
            end
            default: begin
              res_push   = 1'b1;
              res.last   = 1'b1;
              res.status = ST_UNUSED;
            end
          endcase
        end
      end
      S_WALK: begin
        if (!res_full) begin
          unique case (cur_kind)
            KIND_LITERAL: begin
              if (chars_r == CHAR_W'(MAX_CHARS)) begin
                res_push   = 1'b1;
                res.last   = 1'b1;
                res.status = ST_OVERFLOW;
                state_nxt  = S_IDLE;
              end else begin
                // a non-final result in the last slot is replaced by the error
                res_push = !(SUPPRESS_EN && !stk_empty &&
                             chars_r == CHAR_W'(RESULT_LIMIT - 1));
                res.char_bytes = utf8_mask(rd_ent_r.data, lit_len);
                res.char_len   = lit_len;
                res.last       = stk_empty;
                res.status     = ST_OK;
                chars_nxt      = chars_r + CHAR_W'(1);
                if (stk_empty) begin
                  state_nxt = S_IDLE;
                end else begin
                  rd_en     = 1'b1;
                  rd_addr   = stk_r[top_idx];
                  level_nxt = level_r - LVL_W'(1);
                end
              end
            end
            KIND_PAIR: begin
              if (stk_full) begin
                res_push   = 1'b1;
                res.last   = 1'b1;
                res.status = ST_OVERFLOW;
                state_nxt  = S_IDLE;
              end else begin
                stk_push  = 1'b1;
                level_nxt = level_r + LVL_W'(1);
                rd_en     = 1'b1;
                rd_addr   = rd_ent_r.data[15:8];
              end
            end
            default: begin
              res_push   = 1'b1;
              res.last   = 1'b1;
              res.status = ST_UNUSED;
              state_nxt  = S_IDLE;
            end
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) tab_mem[cmd.code[TAB_AW-1:0]] <= '{kind: cmd.kind, data: cmd.data};
    if (rd_en) begin
      rd_ent_r <= tab_mem[rd_addr[TAB_AW-1:0]];
      rd_vld_r <= tab_vld_r[rd_addr[TAB_AW-1:0]];
      rd_bad_r <= !code_ok(rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (stk_push) stk_r[level_r[SP_W-1:0]] <= rd_ent_r.data[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_vld_r <= '0;
    end else if (wr_en) begin
      tab_vld_r[cmd.code[TAB_AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      level_r <= '0;
      chars_r <= '0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
      chars_r <= chars_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bpe_sva_checker.sv @@
`default_nettype none
`include "bpe_symbol_expander_unit_defines.svh"

module bpe_sva_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [31:0] out_char_bytes,
  input logic [2:0]  out_char_len,
  input logic        out_last,
  input logic [1:0]  out_status
);
  import bpe_pkg::*;

  // any non-ok status closes the decode
  `BPE_ASSERT_IMP(a_status_last, !out_empty && out_status != ST_OK, out_last)

  // characters carry ok status and one to four bytes
  `BPE_ASSERT_IMP(a_char_len, !out_empty && out_status == ST_OK, out_char_len != 3'd0 && out_char_len <= 3'd4)

  // bytes beyond a one-byte character's length are zero
  `BPE_ASSERT_IMP(a_char_pad, !out_empty && out_char_len == 3'd1, out_char_bytes[31:8] == 24'h0)

  // stalled result stays put
  `BPE_ASSERT_NXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_char_bytes) && $stable(out_status))

endmodule

bind bpe_symbol_expander_unit bpe_sva_checker u_bpe_sva_checker (.*);

`default_nettype wire
